>>> hdl/lbs_pkg.sv
package lbs_pkg;

  localparam int unsigned LBS_TIMING_W = 6;
  localparam int unsigned LBS_LATCH_W  = 20;
  localparam int unsigned LBS_CFG_W    = 20;
  localparam int unsigned LBS_CFG_IDX_W = 2;

  localparam logic [LBS_CFG_IDX_W-1:0] LBS_CFG_HIGH  = 2'd0;
  localparam logic [LBS_CFG_IDX_W-1:0] LBS_CFG_DATA  = 2'd1;
  localparam logic [LBS_CFG_IDX_W-1:0] LBS_CFG_LOW   = 2'd2;
  localparam logic [LBS_CFG_IDX_W-1:0] LBS_CFG_LATCH = 2'd3;

  localparam logic [LBS_TIMING_W-1:0] LBS_HIGH_RST  = 6'd5;
  localparam logic [LBS_TIMING_W-1:0] LBS_DATA_RST  = 6'd8;
  localparam logic [LBS_TIMING_W-1:0] LBS_LOW_RST   = 6'd7;
  localparam logic [LBS_LATCH_W-1:0]  LBS_LATCH_RST = 20'd4800;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_last;
  } lbs_item_t;

  typedef struct packed {
    logic      valid;
    lbs_item_t item;
  } lbs_head_t;

endpackage

>>> hdl/lbs_front.sv
module lbs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               byte_valid,
  input  logic [7:0]         data_byte,
  input  logic               frame_last,
  output lbs_pkg::lbs_head_t head,
  input  logic               pop
);
  import lbs_pkg::*;

  lbs_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pull;

  assign in_stall = count[1];
  assign push     = in_valid && !in_stall;
  assign pull     = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{byte_valid: byte_valid, data_byte: data_byte, frame_last: frame_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pull) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pull) begin
        count <= count + 2'd1;
      end else if (pull && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/lbs_back.sv
module lbs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lbs_pkg::LBS_CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::LBS_CFG_W-1:0]     cfg_data,
  input  lbs_pkg::lbs_head_t                head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              line_level,
  output logic                              byte_taken,
  output logic                              frame_done,
  output logic                              busy_res
);
  import lbs_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_LATCH = 2'd2,
    MODE_WAIT  = 2'd3
  } mode_t;

  logic [LBS_TIMING_W-1:0] high_ticks;
  logic [LBS_TIMING_W-1:0] data_ticks;
  logic [LBS_TIMING_W-1:0] low_ticks;
  logic [LBS_LATCH_W-1:0]  latch_ticks;

  mode_t            mode, mode_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       tick_in_bit, tick_in_bit_next;
  logic             last_flag, last_flag_next;
  logic [LBS_LATCH_W-1:0] latch_count, latch_count_next;

  logic [LBS_TIMING_W-1:0] hi_eff, da_eff, lo_eff;
  logic [LBS_LATCH_W-1:0]  latch_eff;
  logic [LBS_TIMING_W:0]   hd_sum;
  logic [8:0]              bit_total;
  logic [8:0]              tick_cur;
  logic [8:0]              tick_inc;

  logic lvl, taken, done, busy;

  assign hi_eff    = (high_ticks == '0) ? LBS_TIMING_W'(1) : high_ticks;
  assign da_eff    = (data_ticks == '0) ? LBS_TIMING_W'(1) : data_ticks;
  assign lo_eff    = (low_ticks == '0) ? LBS_TIMING_W'(1) : low_ticks;
  assign latch_eff = (latch_ticks == '0) ? LBS_LATCH_W'(1) : latch_ticks;
  assign hd_sum    = {1'b0, hi_eff} + {1'b0, da_eff};
  assign bit_total = {2'b00, hd_sum} + {3'b000, lo_eff};

  assign pop = head.valid && (!out_valid || !out_stall);

  always_comb begin
    mode_next        = mode;
    shift_byte_next  = shift_byte;
    bit_index_next   = bit_index;
    tick_in_bit_next = tick_in_bit;
    last_flag_next   = last_flag;
    latch_count_next = latch_count;
    lvl      = 1'b0;
    taken    = 1'b0;
    done     = 1'b0;
    busy     = 1'b1;
    tick_cur = 9'd0;
    tick_inc = 9'd0;

    if (mode == MODE_IDLE || mode == MODE_WAIT) begin
      if (head.item.byte_valid) begin
        shift_byte_next  = head.item.data_byte;
        bit_index_next   = 3'd7;
        tick_in_bit_next = 8'd0;
        last_flag_next   = head.item.frame_last;
        mode_next        = MODE_SEND;
        taken            = 1'b1;
      end else if (mode == MODE_IDLE) begin
        busy = 1'b0;
      end
    end

    if (mode_next == MODE_SEND) begin
      tick_cur = {1'b0, tick_in_bit_next};
      if (tick_cur < {3'b000, hi_eff}) begin
        lvl = 1'b1;
      end else if (tick_cur < {2'b00, hd_sum}) begin
        lvl = shift_byte_next[7];
      end
      tick_inc = tick_cur + 9'd1;
      if (tick_inc >= bit_total) begin
        tick_inc = 9'd0;
        if (bit_index_next != 3'd0) begin
          bit_index_next  = bit_index_next - 3'd1;
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
        end else if (last_flag_next) begin
          last_flag_next   = 1'b0;
          latch_count_next = '0;
          mode_next        = MODE_LATCH;
        end else begin
          mode_next = MODE_WAIT;
        end
      end
      tick_in_bit_next = tick_inc[7:0];
    end else if (mode_next == MODE_LATCH) begin
      latch_count_next = latch_count + LBS_LATCH_W'(1);
      if (latch_count_next >= latch_eff) begin
        done             = 1'b1;
        latch_count_next = '0;
        mode_next        = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_ticks  <= LBS_HIGH_RST;
      data_ticks  <= LBS_DATA_RST;
      low_ticks   <= LBS_LOW_RST;
      latch_ticks <= LBS_LATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        LBS_CFG_HIGH:  high_ticks  <= cfg_data[LBS_TIMING_W-1:0];
        LBS_CFG_DATA:  data_ticks  <= cfg_data[LBS_TIMING_W-1:0];
        LBS_CFG_LOW:   low_ticks   <= cfg_data[LBS_TIMING_W-1:0];
        LBS_CFG_LATCH: latch_ticks <= cfg_data[LBS_LATCH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      shift_byte  <= 8'd0;
      bit_index   <= 3'd7;
      tick_in_bit <= 8'd0;
      last_flag   <= 1'b0;
      latch_count <= '0;
      out_valid   <= 1'b0;
    end else if (pop) begin
      mode        <= mode_next;
      shift_byte  <= shift_byte_next;
      bit_index   <= bit_index_next;
      tick_in_bit <= tick_in_bit_next;
      last_flag   <= last_flag_next;
      latch_count <= latch_count_next;
      out_valid   <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_level <= lvl;
      byte_taken <= taken;
      frame_done <= done;
      busy_res   <= busy;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> busy_res)
    else $error("frame_done without busy_res");

  a_taken_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_taken |-> line_level && busy_res)
    else $error("accepted byte did not start high");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> !last_flag && latch_count == '0)
    else $error("idle with stale frame state");

  a_latch_low: assert property (@(posedge clk) disable iff (rst)
    pop && mode == MODE_LATCH |=> out_valid && !line_level)
    else $error("line not low during latch");

endmodule

>>> hdl/led_strip_bit_serializer_unit.sv
// LED strip one-wire serializer.
// One input beat is one tick of the line waveform: byte_valid, data_byte and
// frame_last say whether a pixel byte is offered on that tick. Every input
// beat yields exactly one output beat: line_level, byte_taken, frame_done and
// busy_res for that tick. Bytes go out MSB first; each bit is high_ticks high,
// data_ticks of the data value, then low_ticks low. After a byte flagged
// frame_last the line holds low for latch_ticks ticks and frame_done pulses.
// Timing registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, the block itself does not enforce it; a zero
// value acts as one. Throughput: one beat per cycle on both sides while the
// receiver does not stall. An accepted beat passes through a two-entry input
// queue that feeds the waveform engine, which holds one output register.
// When the receiver stalls, the output beat holds, the engine pauses and the
// queue fills; in_stall rises once both queue entries are in use.
// Reset returns the engine to idle and restores the register defaults
// (5, 8, 7, 4800); queue and output are emptied.
module led_strip_bit_serializer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lbs_pkg::LBS_CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::LBS_CFG_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              byte_valid,
  input  logic [7:0]                        data_byte,
  input  logic                              frame_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              line_level,
  output logic                              byte_taken,
  output logic                              frame_done,
  output logic                              busy_res
);
  import lbs_pkg::*;

  lbs_head_t head;
  logic      pop;

  lbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .frame_last (frame_last),
    .head       (head),
    .pop        (pop)
  );

  lbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_level (line_level),
    .byte_taken (byte_taken),
    .frame_done (frame_done),
    .busy_res   (busy_res)
  );

endmodule
